FILE: rtl/core/frc_pkg.sv
`timescale 1ns / 1ps

package frc_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 32;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd2;

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  localparam logic [3:0] HDR_VERSION  = 4'd2;
  localparam logic [3:0] HDR_TYPE     = 4'd3;
  localparam logic [3:0] HDR_FLAGS    = 4'd4;
  localparam logic [3:0] HDR_SEQ_HI   = 4'd5;
  localparam logic [3:0] HDR_SEQ_LO   = 4'd6;
  localparam logic [3:0] HDR_LEN_HI   = 4'd7;
  localparam logic [3:0] HDR_LEN_LO   = 4'd8;

  typedef logic [7:0] byte_t;

  function automatic logic [31:0] crc_bit(input logic [31:0] crc);
    crc_bit = {1'b0, crc[31:1]} ^ (crc[0] ? CRC_POLY : 32'h0);
  endfunction

endpackage

FILE: rtl/core/frc_ram.sv
`timescale 1ns / 1ps

module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/frame_receiver_crc32.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                                   Handshake
// in_       input      rx_byte                                   in_valid / in_ready
// out_      output     frame header fields, payload byte, last   out_valid / out_ready
// cfg_      input      register index, write data                cfg_valid / cfg_ready
//
// A byte that enters the CRC is accepted and then passes through the serial CRC
// unit, which folds in two bits per cycle; other bytes are only accepted. Each
// result of a good frame passes through M_READ (the read of the payload memory),
// M_LOAD and M_OUT, which holds until out_ready; no byte is taken meanwhile.
// Reset is synchronous; the payload memory needs no clearing pass.

module frame_receiver_crc32 #(
  parameter int PAYLOAD_DEPTH = frc_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_frame_type,
  output logic [7:0]                   out_frame_flags,
  output logic [15:0]                  out_frame_sequence,
  output logic [5:0]                   out_payload_length,
  output logic                         out_payload_present,
  output logic [4:0]                   out_payload_index,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);

  import frc_pkg::*;

  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [15:0] DEPTH16 = 16'(PAYLOAD_DEPTH);

  localparam logic [2:0] PH_MAGIC0  = 3'd0;
  localparam logic [2:0] PH_MAGIC1  = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_SHIFT = 3'd1;
  localparam logic [2:0] M_READ  = 3'd2;
  localparam logic [2:0] M_LOAD  = 3'd3;
  localparam logic [2:0] M_OUT   = 3'd4;

  byte_t magic_first_r, magic_second_r, version_exp_r;

  logic [2:0]    mode_r, mode_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [3:0]    hcnt_r, hcnt_nxt;
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [1:0]    ccnt_r, ccnt_nxt;
  logic [23:0]   rcrc_r, rcrc_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [1:0]    shcnt_r, shcnt_nxt;
  logic [CW-1:0] emit_idx_r, emit_idx_nxt;

  byte_t         ver_r, ver_nxt;
  byte_t         type_r, type_nxt;
  byte_t         flags_r, flags_nxt;
  logic [15:0]   seq_r, seq_nxt;
  byte_t         len_hi_r, len_hi_nxt;

  logic          out_valid_r, out_valid_nxt;
  byte_t         o_type_r, o_flags_r, o_byte_r;
  logic [15:0]   o_seq_r;
  logic [5:0]    o_len_r;
  logic          o_present_r, o_last_r;
  logic [4:0]    o_index_r;

  logic          in_acc;
  byte_t         b;
  logic [15:0]   len_full;
  logic [CW-1:0] pcnt_inc;
  logic [CW-1:0] emit_cnt;
  logic          emit_last;
  logic          load_out;
  logic          ram_we;
  byte_t         ram_rdata;

  assign in_ready  = (mode_r == M_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign b         = in_rx_byte;
  assign len_full  = {len_hi_r, b};
  assign pcnt_inc  = pcnt_r + 1'b1;
  assign emit_cnt  = (len_r == '0) ? CW'(1) : len_r;
  assign emit_last = ((emit_idx_r + 1'b1) == emit_cnt);
  assign load_out  = (mode_r == M_LOAD);
  assign ram_we    = in_acc && (phase_r == PH_PAYLOAD);
  assign cfg_ready = 1'b1;

  frc_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pcnt_r[AW-1:0]),
    .wdata (b),
    .re    (mode_r == M_READ),
    .raddr (emit_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    hcnt_nxt      = hcnt_r;
    pcnt_nxt      = pcnt_r;
    len_nxt       = len_r;
    ccnt_nxt      = ccnt_r;
    rcrc_nxt      = rcrc_r;
    crc_nxt       = crc_r;
    shcnt_nxt     = shcnt_r;
    emit_idx_nxt  = emit_idx_r;
    ver_nxt       = ver_r;
    type_nxt      = type_r;
    flags_nxt     = flags_r;
    seq_nxt       = seq_r;
    len_hi_nxt    = len_hi_r;
    out_valid_nxt = out_valid_r;

    case (mode_r)
      M_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_MAGIC0: begin
              if (b == magic_first_r) begin
                crc_nxt   = CRC_INIT ^ {24'h0, b};
                hcnt_nxt  = 4'd1;
                phase_nxt = PH_MAGIC1;
                mode_nxt  = M_SHIFT;
              end
            end
            PH_MAGIC1: begin
              if (b == magic_second_r) begin
                crc_nxt   = crc_r ^ {24'h0, b};
                hcnt_nxt  = 4'd2;
                phase_nxt = PH_HEADER;
                mode_nxt  = M_SHIFT;
              end else begin
                phase_nxt = PH_MAGIC0;
                hcnt_nxt  = '0;
                crc_nxt   = CRC_INIT;
              end
            end
            PH_HEADER: begin
              hcnt_nxt = hcnt_r + 4'd1;
              crc_nxt  = crc_r ^ {24'h0, b};
              mode_nxt = M_SHIFT;
              case (hcnt_r)
                HDR_VERSION: ver_nxt         = b;
                HDR_TYPE:    type_nxt        = b;
                HDR_FLAGS:   flags_nxt       = b;
                HDR_SEQ_HI:  seq_nxt[15:8]   = b;
                HDR_SEQ_LO:  seq_nxt[7:0]    = b;
                HDR_LEN_HI:  len_hi_nxt      = b;
                default: begin
                end
              endcase
              if (hcnt_r == HDR_LEN_LO) begin
                if (ver_r != version_exp_r || len_full > DEPTH16) begin
                  phase_nxt = PH_MAGIC0;
                  hcnt_nxt  = '0;
                  crc_nxt   = CRC_INIT;
                  mode_nxt  = M_IDLE;
                end else begin
                  len_nxt   = CW'(len_full);
                  pcnt_nxt  = '0;
                  ccnt_nxt  = '0;
                  phase_nxt = (len_full == 16'h0) ? PH_CRC : PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              pcnt_nxt = pcnt_inc;
              crc_nxt  = crc_r ^ {24'h0, b};
              mode_nxt = M_SHIFT;
              if (pcnt_inc >= len_r) begin
                ccnt_nxt  = '0;
                phase_nxt = PH_CRC;
              end
            end
            PH_CRC: begin
              rcrc_nxt = {rcrc_r[15:0], b};
              ccnt_nxt = ccnt_r + 2'd1;
              if (ccnt_r == 2'd3) begin
                if (~crc_r == {rcrc_r, b}) begin
                  emit_idx_nxt = '0;
                  mode_nxt     = M_READ;
                end
                phase_nxt = PH_MAGIC0;
                hcnt_nxt  = '0;
                pcnt_nxt  = '0;
                ccnt_nxt  = '0;
                crc_nxt   = CRC_INIT;
              end
            end
            default: begin
              phase_nxt = PH_MAGIC0;
              hcnt_nxt  = '0;
              pcnt_nxt  = '0;
              ccnt_nxt  = '0;
              crc_nxt   = CRC_INIT;
            end
          endcase
        end
      end
      M_SHIFT: begin
        crc_nxt   = crc_bit(crc_bit(crc_r));
        shcnt_nxt = shcnt_r + 2'd1;
        if (shcnt_r == 2'd3) begin
          mode_nxt = M_IDLE;
        end
      end
      M_READ: begin
        mode_nxt = M_LOAD;
      end
      M_LOAD: begin
        out_valid_nxt = 1'b1;
        mode_nxt      = M_OUT;
      end
      M_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (emit_last) begin
            mode_nxt = M_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
            mode_nxt     = M_READ;
          end
        end
      end
      default: begin
        mode_nxt      = M_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= '0;
      magic_second_r <= '0;
      version_exp_r  <= '0;
      mode_r         <= M_IDLE;
      phase_r        <= PH_MAGIC0;
      hcnt_r         <= '0;
      pcnt_r         <= '0;
      len_r          <= '0;
      ccnt_r         <= '0;
      crc_r          <= CRC_INIT;
      shcnt_r        <= '0;
      emit_idx_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC_FIRST:      magic_first_r  <= cfg_data;
          REG_MAGIC_SECOND:     magic_second_r <= cfg_data;
          REG_EXPECTED_VERSION: version_exp_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      hcnt_r      <= hcnt_nxt;
      pcnt_r      <= pcnt_nxt;
      len_r       <= len_nxt;
      ccnt_r      <= ccnt_nxt;
      crc_r       <= crc_nxt;
      shcnt_r     <= shcnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rcrc_r   <= rcrc_nxt;
    ver_r    <= ver_nxt;
    type_r   <= type_nxt;
    flags_r  <= flags_nxt;
    seq_r    <= seq_nxt;
    len_hi_r <= len_hi_nxt;
    if (load_out) begin
      o_type_r    <= type_r;
      o_flags_r   <= flags_r;
      o_seq_r     <= seq_r;
      o_len_r     <= 6'(len_r);
      o_present_r <= (len_r != '0);
      o_index_r   <= (len_r != '0) ? 5'(emit_idx_r) : 5'd0;
      o_byte_r    <= (len_r != '0) ? ram_rdata : 8'h00;
      o_last_r    <= emit_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_type      = o_type_r;
  assign out_frame_flags     = o_flags_r;
  assign out_frame_sequence  = o_seq_r;
  assign out_payload_length  = o_len_r;
  assign out_payload_present = o_present_r;
  assign out_payload_index   = o_index_r;
  assign out_payload_byte    = o_byte_r;
  assign out_last            = o_last_r;

  a_no_rx_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Byte transaction possible while a result is pending.");

  a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_SHIFT && shcnt_r == 2'd3) |=> (mode_r == M_IDLE))
    else $error("CRC unit did not finish after four cycles.");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload_present) |-> out_last)
    else $error("Empty frame result is not marked last.");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("Input not released after the final result.");

  a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (len_r != '0 && pcnt_r < len_r))
    else $error("Payload count outside the declared length.");

endmodule
